// ===== rtl/core/lfps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the position-error function of the line follower PD steering block.
// No dependencies; used by lfps_ctrl, lfps_dp and line_follower_pd_steering.
package lfps_pkg;

    localparam int GAIN_W  = 12;
    localparam int DUTY_W  = 10;
    localparam int SENS_W  = 5;
    localparam int ERR_W   = 3;
    localparam int DELTA_W = 4;
    localparam int ACC_W   = 16;
    localparam int SUM_W   = 17;
    localparam int CIDX_W  = 2;

    localparam int DUTY_MAX_DEF = 1023;
    localparam int FIELD_TOP    = (1 << DUTY_W) - 1;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 12'd150;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 12'd80;
    localparam logic [DUTY_W-1:0] BASE_SPEED_RST = 10'd600;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_DERIV_GAIN = 2'd1,
        CFG_BASE_SPEED = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_D,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic calc_err;
        logic mul_p;
        logic mul_d;
        logic load_out;
    } t_dp_cmd;

    // Weighted position of the set bits divided by their count, truncated toward zero.
    // With no bit set the sign of the previous error decides.
    function automatic logic signed [ERR_W-1:0] pos_error(
        input logic [SENS_W-1:0]        bits,
        input logic signed [ERR_W-1:0]  prev
    );
        logic signed [3:0] sum;
        logic [2:0]        cnt;
        logic [1:0]        mag;
        logic [1:0]        q;
        logic signed [ERR_W-1:0] res;
        sum = '0;
        cnt = '0;
        for (int i = 0; i < SENS_W; i++) begin
            if (bits[i]) begin
                sum = sum + $signed(4'(i - 2));
                cnt = cnt + 3'd1;
            end
        end
        mag = sum[3] ? 2'(-sum) : sum[1:0];
        if ({1'b0, cnt} == 4'd0) begin
            q = 2'd0;
        end else if ({2'b00, mag} >= {cnt, 1'b0}) begin
            q = 2'd2;
        end else if ({1'b0, mag} >= cnt) begin
            q = 2'd1;
        end else begin
            q = 2'd0;
        end
        if (cnt == 3'd0) begin
            if (prev < 0) begin
                res = -3'sd2;
            end else if (prev > 0) begin
                res = 3'sd2;
            end else begin
                res = 3'sd0;
            end
        end else if (sum[3]) begin
            res = -$signed({1'b0, q});
        end else begin
            res = $signed({1'b0, q});
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lfps_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the line follower PD steering block.
// Depends on lfps_pkg; drives the datapath commands and both handshakes.
module lfps_ctrl
    import lfps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;
    logic   out_free;

    assign out_free = !r_out_full || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_ERR;
            ST_ERR:   n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            ST_ERR:   o_cmd.calc_err = 1'b1;
            ST_MUL_P: o_cmd.mul_p    = 1'b1;
            ST_MUL_D: o_cmd.mul_d    = 1'b1;
            ST_DONE:  o_cmd.load_out = out_free;
            default:  o_cmd = '0;
        endcase
    end

    // The result register stays full until the receiver takes the transaction.
    always_comb begin
        n_out_full = r_out_full;
        if (o_cmd.load_out) begin
            n_out_full = 1'b1;
        end else if (!i_out_stall) begin
            n_out_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

    assign o_out_valid = r_out_full;

endmodule

// ===== rtl/core/lfps_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the line follower PD steering block: gain registers, error state,
// one shared gain multiplier, accumulator and duty clamps. Depends on lfps_pkg.
module lfps_dp
    import lfps_pkg::*;
#(
    parameter int DUTY_MAX = DUTY_MAX_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]   i_cfg_data,
    input  logic [SENS_W-1:0]   i_sensor_bits,
    output logic [DUTY_W-1:0]   o_left_duty,
    output logic [DUTY_W-1:0]   o_right_duty,
    output logic                o_line_lost
);

    localparam int DUTY_TOP = (DUTY_MAX > FIELD_TOP) ? FIELD_TOP : DUTY_MAX;

    logic [GAIN_W-1:0]        r_prop_gain;
    logic [GAIN_W-1:0]        r_deriv_gain;
    logic [DUTY_W-1:0]        r_base_speed;
    logic signed [ERR_W-1:0]  r_prev_err;
    logic [SENS_W-1:0]        r_bits;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_lost;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DUTY_W-1:0]        r_left;
    logic [DUTY_W-1:0]        r_right;
    logic                     r_lost_out;

    logic signed [ERR_W-1:0]   err_now;
    logic [GAIN_W-1:0]         mul_a;
    logic signed [DELTA_W-1:0] mul_b;
    logic signed [ACC_W:0]     product;
    logic signed [SUM_W-1:0]   base_s;
    logic signed [SUM_W-1:0]   left_sum;
    logic signed [SUM_W-1:0]   right_sum;

    assign err_now = pos_error(r_bits, r_prev_err);

    // One multiplier serves both terms: gain times error, then gain times error change.
    assign mul_a   = i_cmd.mul_d ? r_deriv_gain : r_prop_gain;
    assign mul_b   = i_cmd.mul_d ? r_delta : DELTA_W'(r_err);
    assign product = $signed({1'b0, mul_a}) * mul_b;

    assign base_s    = $signed(SUM_W'(r_base_speed));
    assign left_sum  = base_s + SUM_W'(r_acc);
    assign right_sum = base_s - SUM_W'(r_acc);

    function automatic logic [DUTY_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
        logic [DUTY_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed(SUM_W'(DUTY_TOP))) begin
            res = DUTY_W'(DUTY_TOP);
        end else begin
            res = v[DUTY_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_base_speed <= BASE_SPEED_RST;
            r_prev_err   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                    CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                    CFG_BASE_SPEED: r_base_speed <= i_cfg_data[DUTY_W-1:0];
                    default:        ;
                endcase
            end
            if (i_cmd.calc_err) begin
                r_prev_err <= err_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_bits <= i_sensor_bits;
        end
        if (i_cmd.calc_err) begin
            r_err   <= err_now;
            r_delta <= DELTA_W'(err_now) - DELTA_W'(r_prev_err);
            r_lost  <= (r_bits == '0);
        end
        if (i_cmd.mul_p) begin
            r_acc <= product[ACC_W-1:0];
        end else if (i_cmd.mul_d) begin
            r_acc <= r_acc + product[ACC_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_left     <= clamp(left_sum);
            r_right    <= clamp(right_sum);
            r_lost_out <= r_lost;
        end
    end

    assign o_left_duty  = r_left;
    assign o_right_duty = r_right;
    assign o_line_lost  = r_lost_out;

endmodule

// ===== rtl/core/line_follower_pd_steering.sv =====
`timescale 1ns / 1ps
// PD steering controller for a five-sensor line follower: top level.
// Depends on lfps_pkg, lfps_ctrl and lfps_dp.
//
// Each accepted sample of five sensor bits yields one transaction of left and right
// motor duty plus a line-lost flag. A sample passes through acceptance, the position error,
// two passes through the single shared 12x4 gain multiplier (proportional, then derivative
// term), and the add and clamp, at the end of which the result register loads once it is
// free. The input reopens once the result is loaded, so a waiting result does not hold up
// the next sample; no new sample is taken before the last result is loaded. Duties saturate
// at DUTY_MAX, and never above 1023. Gains and base speed are
// written through the configuration port (index 0 proportional gain, 1 derivative gain,
// 2 base speed; index 3 is ignored) and must only be written while no sample is in flight.
module line_follower_pd_steering
    import lfps_pkg::*;
#(
    parameter int DUTY_MAX = DUTY_MAX_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [SENS_W-1:0]   i_sensor_bits,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [DUTY_W-1:0]   o_left_duty,
    output logic [DUTY_W-1:0]   o_right_duty,
    output logic                o_line_lost,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]   i_cfg_data
);

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    lfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lfps_dp #(
        .DUTY_MAX (DUTY_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sensor_bits (i_sensor_bits),
        .o_left_duty   (o_left_duty),
        .o_right_duty  (o_right_duty),
        .o_line_lost   (o_line_lost)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_follower_pd_steering: predicts duties and line-lost per sample.
// Depends on lfps_pkg and the line_follower_pd_steering RTL; uses random input gaps and output stalls.
module tb;
    import lfps_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 64;
    localparam int DUTY_MAX = DUTY_MAX_DEF;

    typedef struct {
        logic [DUTY_W-1:0] left;
        logic [DUTY_W-1:0] right;
        logic              lost;
    } t_duty_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [SENS_W-1:0]   i_sensor_bits = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DUTY_W-1:0]   o_left_duty;
    logic [DUTY_W-1:0]   o_right_duty;
    logic                o_line_lost;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index = '0;
    logic [GAIN_W-1:0]   i_cfg_data = '0;

    // Predictor state: gains, cruise duty and the error of the last sample.
    int kp_model = 150;
    int kd_model = 80;
    int base_model = 600;
    int last_err = 0;

    t_duty_result duty_expect_q[$];
    int error_count = 0;
    bit in_idle_en = 1'b0;
    bit out_idle_en = 1'b0;
    int unsigned out_stall_left = 0;

    line_follower_pd_steering #(
        .DUTY_MAX (DUTY_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sensor_bits (i_sensor_bits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_duty   (o_left_duty),
        .o_right_duty  (o_right_duty),
        .o_line_lost   (o_line_lost),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void predict_duty(input logic [SENS_W-1:0] bits);
        int wsum;
        int nset;
        int err;
        int corr;
        int left;
        int right;
        int top;
        t_duty_result res;
        wsum = 0;
        nset = 0;
        for (int i = 0; i < SENS_W; i++) begin
            if (bits[i]) begin
                wsum += i - 2;
                nset++;
            end
        end
        if (nset == 0) begin
            // Line lost: steer hard toward the side where the line was last seen.
            err = (last_err < 0) ? -2 : (last_err > 0) ? 2 : 0;
        end else begin
            err = wsum / nset;
        end
        corr = kp_model * err + kd_model * (err - last_err);
        last_err = err;
        top = (DUTY_MAX > 1023) ? 1023 : DUTY_MAX;
        left = base_model + corr;
        right = base_model - corr;
        left = (left < 0) ? 0 : (left > top) ? top : left;
        right = (right < 0) ? 0 : (right > top) ? top : right;
        res.left = 10'(left);
        res.right = 10'(right);
        res.lost = (nset == 0);
        duty_expect_q.push_back(res);
    endfunction

    function automatic logic [SENS_W-1:0] pick_sensor_bits();
        int unsigned kind;
        int unsigned pos;
        logic [SENS_W-1:0] v;
        kind = $urandom_range(0, 9);
        pos = $urandom_range(0, SENS_W - 1);
        if (kind < 2) begin
            v = '0;
        end else if (kind < 7) begin
            // A line under one sensor or straddling two neighbors.
            v = 5'b00001 << pos;
            if (kind >= 5) begin
                v = v | (v << 1);
            end
        end else begin
            v = 5'($urandom);
        end
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return 12'($urandom_range(0, 400));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SENS_W-1:0] bits);
        if (in_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sensor_bits <= bits;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_duty(bits);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (duty_expect_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PROP_GAIN: kp_model = int'(data);
            CFG_DERIV_GAIN: kd_model = int'(data);
            CFG_BASE_SPEED: base_model = int'(data[DUTY_W-1:0]);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Default gains; covers every weighting, ties, and line lost after each error sign.
    task automatic test_error_cases();
        send_sample(5'b00100);
        send_sample(5'b00001);
        send_sample(5'b10000);
        send_sample(5'b00000);
        send_sample(5'b11111);
        send_sample(5'b00000);
        send_sample(5'b00011);
        send_sample(5'b00000);
        send_sample(5'b11000);
        send_sample(5'b01110);
        send_sample(5'b10001);
        send_sample(5'b11100);
        send_sample(5'b00111);
        wait_idle();
    endtask

    // Register extremes: saturation at both ends, truncated base speed, ignored index.
    task automatic test_config_extremes();
        write_reg(CFG_PROP_GAIN, 12'hFFF);
        write_reg(CFG_DERIV_GAIN, 12'hFFF);
        write_reg(CFG_BASE_SPEED, 12'h000);
        send_sample(5'b10000);
        send_sample(5'b00001);
        send_sample(5'b00000);
        wait_idle();
        write_reg(CFG_PROP_GAIN, 12'h000);
        write_reg(CFG_DERIV_GAIN, 12'h000);
        write_reg(CFG_BASE_SPEED, 12'hFFF);
        send_sample(5'b00001);
        wait_idle();
        write_reg(CFG_IDX_UNUSED, 12'hA5A);
        write_reg(CFG_BASE_SPEED, 12'hC37);
        send_sample(5'b01000);
        send_sample(5'b00000);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_reg(CFG_PROP_GAIN, pick_gain());
            write_reg(CFG_DERIV_GAIN, pick_gain());
            write_reg(CFG_BASE_SPEED, 12'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The last phase runs at full rate on both sides.
                if (n % 16 == 0) begin
                    in_idle_en = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
                    out_idle_en = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
                end
                send_sample(pick_sensor_bits());
            end
            wait_idle();
        end
    endtask

    // Output stall in random bursts while out_idle_en is set.
    always @(posedge i_clk) begin
        if (!out_idle_en) begin
            i_out_stall <= 1'b0;
            out_stall_left <= 0;
        end else if (out_stall_left != 0) begin
            out_stall_left <= out_stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            out_stall_left <= $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_duty_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (duty_expect_q.size() == 0) begin
                $error("unexpected result transaction: left %0d right %0d lost %0b",
                       o_left_duty, o_right_duty, o_line_lost);
                error_count++;
            end else begin
                want = duty_expect_q.pop_front();
                if (o_left_duty !== want.left) begin
                    $error("left_duty: expected %0d, actual %0d", want.left, o_left_duty);
                    error_count++;
                end
                if (o_right_duty !== want.right) begin
                    $error("right_duty: expected %0d, actual %0d", want.right, o_right_duty);
                    error_count++;
                end
                if (o_line_lost !== want.lost) begin
                    $error("line_lost: expected %0b, actual %0b", want.lost, o_line_lost);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        test_error_cases();
        test_config_extremes();
        test_random_phases();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lfps_pkg.sv
rtl/core/lfps_ctrl.sv
rtl/core/lfps_dp.sv
rtl/core/line_follower_pd_steering.sv
tb/tb.sv
